>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the curve sampler checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define BCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs through reset
`define BCS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// shared types and constants of the bezier curve sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcs_pkg;

    localparam int IO_BITS         = 32;
    localparam int FRAC_BITS       = 16;
    localparam int DIV_STEPS       = 16;
    localparam int IDX_BITS        = 4;
    localparam int SNUM_BITS       = 6;
    localparam int PC_BITS         = 5;
    localparam int SC_BITS         = 7;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 7;
    localparam int LANES           = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT = 1'b1;

    localparam logic [PC_BITS-1:0] PC_RESET = 5'd4;
    localparam logic [SC_BITS-1:0] SC_RESET = 7'd64;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_GENERATE = 1'b1;

    typedef struct packed {
        logic store_we;
        logic div_init;
        logic div_step;
        logic copy_req;
        logic mul;
        logic shift;
        logic ins;
        logic emit;
        logic last;
    } t_dp_cmd;

endpackage

>>> hw/rtl/bcs_ram.sv
// ----------------------------------------------------------------------------
// bcs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bcs_ctrl.sv
// ----------------------------------------------------------------------------
// bcs_ctrl
// sequencer for load, t division, point copy, lerp rounds and sample output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcs_ctrl #(
    parameter int MAX_POINTS  = 16,
    parameter int MAX_SAMPLES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bcs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bcs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bcs_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]       o_copy_addr,
    output logic [$clog2(MAX_POINTS)-1:0]       o_ins_pos,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]    o_sample,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]    o_divisor
);

    import bcs_pkg::*;

    localparam int PA = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = $clog2(MAX_SAMPLES + 1);
    localparam int KW = (NW > 5) ? NW : 5;
    localparam int CW = (NW > PC_BITS) ? NW : PC_BITS;

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_DIV  = 7'b000_0010,
        S_COPY = 7'b000_0100,
        S_MUL  = 7'b000_1000,
        S_ACC  = 7'b001_0000,
        S_DROP = 7'b010_0000,
        S_EMIT = 7'b100_0000
    } t_state;

    t_state             r_state, n_state;
    logic [PC_BITS-1:0] r_point_count;
    logic [SC_BITS-1:0] r_sample_count;
    logic [SW-1:0]      r_sample, n_sample;
    logic [KW-1:0]      r_cnt, n_cnt;
    logic [PA-1:0]      r_round, n_round;
    logic [PA-1:0]      r_step, n_step;
    logic               r_out_valid, n_out_valid;

    logic [CW-1:0]      pc_ext;
    logic [NW-1:0]      n_pts;
    logic [SW-1:0]      s_eff;
    logic               in_accept;
    logic               out_free;
    logic               is_last;
    t_dp_cmd            cmd;

    // clamp the configured counts to the supported ranges
    assign pc_ext = CW'(r_point_count);

    always_comb begin
        if (pc_ext < CW'(2)) begin
            n_pts = NW'(2);
        end else if (pc_ext > CW'(MAX_POINTS)) begin
            n_pts = NW'(MAX_POINTS);
        end else begin
            n_pts = NW'(pc_ext);
        end
    end

    always_comb begin
        if (r_sample_count == '0) begin
            s_eff = SW'(1);
        end else if (r_sample_count > SC_BITS'(MAX_SAMPLES)) begin
            s_eff = SW'(MAX_SAMPLES);
        end else begin
            s_eff = SW'(r_sample_count);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_last    = (r_sample == s_eff - SW'(1));

    always_comb begin
        n_state  = r_state;
        n_sample = r_sample;
        n_cnt    = r_cnt;
        n_round  = r_round;
        n_step   = r_step;
        cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_func == FUNC_LOAD) begin
                        cmd.store_we = 1'b1;
                    end else begin
                        n_sample = '0;
                        n_cnt    = '0;
                        n_state  = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    cmd.div_init = 1'b1;
                end else begin
                    cmd.div_step = 1'b1;
                end
                if (r_cnt == KW'(DIV_STEPS)) begin
                    n_cnt   = '0;
                    n_state = S_COPY;
                end else begin
                    n_cnt = r_cnt + KW'(1);
                end
            end
            S_COPY: begin
                cmd.copy_req = (r_cnt < KW'(n_pts));
                if (r_cnt == KW'(n_pts)) begin
                    n_round = PA'(n_pts - NW'(1));
                    n_step  = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + KW'(1);
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                cmd.shift = 1'b1;
                cmd.ins   = 1'b1;
                if (r_step == r_round - PA'(1)) begin
                    n_state = S_DROP;
                end else begin
                    n_step  = r_step + PA'(1);
                    n_state = S_MUL;
                end
            end
            S_DROP: begin
                cmd.shift = 1'b1;
                if (r_round == PA'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_round = r_round - PA'(1);
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sample = r_sample + SW'(1);
                        n_cnt    = '0;
                        n_state  = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_point_count  <= PC_RESET;
            r_sample_count <= SC_RESET;
            r_sample       <= '0;
            r_cnt          <= '0;
            r_round        <= '0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sample    <= n_sample;
            r_cnt       <= n_cnt;
            r_round     <= n_round;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_POINT_COUNT) begin
                    r_point_count <= i_cfg_data[PC_BITS-1:0];
                end
                if (i_cfg_index == REG_SAMPLE_COUNT) begin
                    r_sample_count <= i_cfg_data[SC_BITS-1:0];
                end
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_copy_addr = r_cnt[PA-1:0];
    assign o_ins_pos   = r_round;
    assign o_sample    = r_sample;
    assign o_divisor   = s_eff;
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/bcs_dp.sv
// ----------------------------------------------------------------------------
// bcs_dp
// control point store, t divider, three lerp lanes and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcs_dp #(
    parameter int MAX_POINTS  = 16,
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bcs_pkg::t_dp_cmd                     i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_copy_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_ins_pos,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0]     i_sample,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0]     i_divisor,
    input  logic [bcs_pkg::IDX_BITS-1:0]         i_point_index,
    input  logic signed [bcs_pkg::IO_BITS-1:0]   i_in_x,
    input  logic signed [bcs_pkg::IO_BITS-1:0]   i_in_y,
    input  logic signed [bcs_pkg::IO_BITS-1:0]   i_in_z,
    output logic signed [bcs_pkg::IO_BITS-1:0]   o_out_x,
    output logic signed [bcs_pkg::IO_BITS-1:0]   o_out_y,
    output logic signed [bcs_pkg::IO_BITS-1:0]   o_out_z,
    output logic [bcs_pkg::SNUM_BITS-1:0]        o_sample_number,
    output logic                                 o_last
);

    import bcs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PA = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = ((PA > IDX_BITS) ? PA : IDX_BITS) + 1;

    // store write side
    logic [IW-1:0]        idx_ext;
    logic                 slot_ok;
    logic [LANES*CB-1:0]  wdata;
    logic [LANES*CB-1:0]  rdata;

    assign idx_ext = IW'(i_point_index);
    assign slot_ok = (idx_ext < IW'(MAX_POINTS));
    assign wdata   = {CB'(i_in_z), CB'(i_in_y), CB'(i_in_x)};

    bcs_ram #(
        .WIDTH (LANES * CB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_we && slot_ok),
        .i_waddr (idx_ext[PA-1:0]),
        .i_wdata (wdata),
        .i_raddr (i_copy_addr),
        .o_rdata (rdata)
    );

    logic          r_copy_wr;
    logic [PA-1:0] r_copy_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy_wr <= 1'b0;
        end else begin
            r_copy_wr <= i_cmd.copy_req;
        end
        r_copy_pos <= i_copy_addr;
    end

    // restoring divider, t = floor(i * 2^16 / s), one quotient bit a step
    logic [SW-1:0]        r_rem;
    logic [FRAC_BITS-1:0] r_t;
    logic [SW:0]          rem2;
    logic                 rem_ge;
    logic signed [FRAC_BITS:0] t_s;

    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, i_divisor});
    assign t_s    = $signed({1'b0, r_t});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= i_sample;
            r_t   <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= SW'(rem2 - {1'b0, i_divisor});
                r_t   <= {r_t[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= SW'(rem2);
                r_t   <= {r_t[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    logic signed [CB-1:0] w_head [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic signed [CB-1:0]         r_line [MAX_POINTS];
        logic signed [CB-1:0]         r_p;
        logic [CB-1:0]                r_ph;
        logic [FRAC_BITS-1:0]         r_pl;
        logic signed [CB:0]           diff;
        logic signed [CB-FRAC_BITS:0] hi;
        logic [FRAC_BITS-1:0]         lo;
        logic signed [CB+1:0]         prod_hi;
        logic [2*FRAC_BITS-1:0]       prod_lo;
        logic [CB-1:0]                lerp_val;

        // p + floor((q - p) * t / 2^16), split into high and low parts of q - p
        assign diff     = (CB+1)'(r_line[1]) - (CB+1)'(r_line[0]);
        assign hi       = $signed(diff[CB:FRAC_BITS]);
        assign lo       = diff[FRAC_BITS-1:0];
        assign prod_hi  = (CB+2)'(hi) * (CB+2)'(t_s);
        assign prod_lo  = (2*FRAC_BITS)'(lo) * (2*FRAC_BITS)'(r_t);
        assign lerp_val = r_p + r_ph + CB'(r_pl);

        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_p  <= r_line[0];
                r_ph <= prod_hi[CB-1:0];
                r_pl <= prod_lo[2*FRAC_BITS-1:FRAC_BITS];
            end
        end

        // shift line, the head drops out and the new point enters at the end of the active part
        for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
            always_ff @(posedge i_clk) begin
                if (i_cmd.shift) begin
                    if (i_cmd.ins && i_ins_pos == PA'(k)) begin
                        r_line[k] <= lerp_val;
                    end else if (k < MAX_POINTS - 1) begin
                        r_line[k] <= r_line[(k < MAX_POINTS - 1) ? k + 1 : k];
                    end
                end else if (r_copy_wr && r_copy_pos == PA'(k)) begin
                    r_line[k] <= rdata[g*CB +: CB];
                end
            end
        end

        assign w_head[g] = r_line[0];
    end

    logic signed [IO_BITS-1:0] r_out_x;
    logic signed [IO_BITS-1:0] r_out_y;
    logic signed [IO_BITS-1:0] r_out_z;
    logic [SNUM_BITS-1:0]      r_snum;
    logic                      r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x <= IO_BITS'(w_head[0]);
            r_out_y <= IO_BITS'(w_head[1]);
            r_out_z <= IO_BITS'(w_head[2]);
            r_snum  <= SNUM_BITS'(i_sample);
            r_last  <= i_cmd.last;
        end
    end

    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_z         = r_out_z;
    assign o_sample_number = r_snum;
    assign o_last          = r_last;

endmodule

>>> hw/rtl/bezier_curve_sampler.sv
// ----------------------------------------------------------------------------
// bezier_curve_sampler
// Load items (func 0) write one Q16.16 control point into a store slot and
// are taken one per cycle while no generate run is in progress. A generate
// item (func 1) emits sample_count curve points (clamped to 1..MAX_SAMPLES)
// at t = i / sample_count, evaluated by de Casteljau with a 16-bit t. Each
// sample passes through the bit-serial divider that forms t, a copy of the
// points in use out of the store, the lerp rounds, where one lerp unit per
// coordinate, with a multiply and an accumulate state, does every lerp of a
// round in turn and each round ends with one shift of the working line, and
// a hand-off of the sample to the output register. The output register lets
// the next sample be worked on while the previous one waits to be taken; no
// new request is taken until the last sample of a run has been handed to the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bezier_curve_sampler #(
    parameter int MAX_POINTS  = 16,
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bcs_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [bcs_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic [bcs_pkg::IDX_BITS-1:0]         i_point_index,
    input  logic signed [bcs_pkg::IO_BITS-1:0]   i_in_x,
    input  logic signed [bcs_pkg::IO_BITS-1:0]   i_in_y,
    input  logic signed [bcs_pkg::IO_BITS-1:0]   i_in_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bcs_pkg::IO_BITS-1:0]   o_out_x,
    output logic signed [bcs_pkg::IO_BITS-1:0]   o_out_y,
    output logic signed [bcs_pkg::IO_BITS-1:0]   o_out_z,
    output logic [bcs_pkg::SNUM_BITS-1:0]        o_sample_number,
    output logic                                 o_last
);

    import bcs_pkg::*;

    localparam int PA = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_SAMPLES + 1);

    t_dp_cmd       cmd;
    logic [PA-1:0] copy_addr;
    logic [PA-1:0] ins_pos;
    logic [SW-1:0] sample;
    logic [SW-1:0] divisor;

    bcs_ctrl #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .o_copy_addr (copy_addr),
        .o_ins_pos   (ins_pos),
        .o_sample    (sample),
        .o_divisor   (divisor)
    );

    bcs_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_copy_addr     (copy_addr),
        .i_ins_pos       (ins_pos),
        .i_sample        (sample),
        .i_divisor       (divisor),
        .i_point_index   (i_point_index),
        .i_in_x          (i_in_x),
        .i_in_y          (i_in_y),
        .i_in_z          (i_in_z),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_sample_number (o_sample_number),
        .o_last          (o_last)
    );

endmodule

>>> hw/rtl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// port level checks of the curve sampler, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcs_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 i_func,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [bcs_pkg::IO_BITS-1:0]   o_out_x,
    input logic signed [bcs_pkg::IO_BITS-1:0]   o_out_y,
    input logic signed [bcs_pkg::IO_BITS-1:0]   o_out_z,
    input logic [bcs_pkg::SNUM_BITS-1:0]        o_sample_number,
    input logic                                 o_last
);

    import bcs_pkg::*;

    // a held result keeps its payload
    `BCS_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_sample_number) && $stable(o_last)), "output payload changed while stalled")

    // a generate request blocks further requests
    `BCS_ASSERT(a_gen_busy, (i_in_valid && o_in_ready && i_func == FUNC_GENERATE) |=> !o_in_ready, "request taken right after a generate request")

    // a run stays busy until its last sample reaches the output register
    `BCS_ASSERT(a_run_busy, (o_out_valid && !o_last) |-> !o_in_ready, "block idle before the last sample of a run")

    // reset leaves the block idle and empty
    `BCS_ASSERT_RST(a_rst_clear, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset did not clear the block")

endmodule

bind bezier_curve_sampler bcs_checker u_bcs_checker (.*);
